@@ rtl/core/afr_pkg.sv @@
// Shared types and constants for the addressed frame receiver.
// Depends on nothing; every other file of the block but afr_ram uses it.
package afr_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'h24;
    localparam logic [BYTE_W-1:0] STOP_BYTE  = 8'h26;
    localparam logic [LEN_W-1:0]  MIN_KEEP   = 6'd2;

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] S_IDLE  = 3'd0;
    localparam logic [ST_W-1:0] S_ADDR  = 3'd1;
    localparam logic [ST_W-1:0] S_FILL  = 3'd2;
    localparam logic [ST_W-1:0] S_READY = 3'd3;
    localparam logic [ST_W-1:0] S_RD    = 3'd4;
    localparam logic [ST_W-1:0] S_OUT   = 3'd5;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [LEN_W-1:0]  t_len;

    typedef struct packed {
        logic  load;
        logic  is_last;
        t_len  frame_length;
    } t_emit;

endpackage

@@ rtl/core/afr_in_if.sv @@
// Input channel of the addressed frame receiver: one received byte per word.
// Depends on afr_pkg for the byte type.
interface afr_in_if;
    logic          valid;
    logic          ready;
    afr_pkg::t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

@@ rtl/core/afr_out_if.sv @@
// Output channel of the addressed frame receiver: one payload byte per word.
// Depends on afr_pkg for the byte and length types.
interface afr_out_if;
    logic           valid;
    logic           ready;
    afr_pkg::t_byte payload_byte;
    logic           is_last;
    afr_pkg::t_len  frame_length;

    modport source (output valid, output payload_byte, output is_last,
                    output frame_length, input ready);
    modport sink (input valid, input payload_byte, input is_last,
                  input frame_length, output ready);
endinterface

@@ rtl/core/afr_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read.
// Depends on nothing.
module afr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/afr_ctrl.sv @@
// Frame state machine, station id register and burst sequencer of the receiver.
// Depends on afr_pkg and drives the write and read ports of the frame store.
module afr_ctrl #(
    parameter int CAPACITY = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  afr_pkg::t_byte              i_cfg_wdata,
    input  logic                        i_in_valid,
    input  afr_pkg::t_byte              i_in_byte,
    output logic                        o_in_ready,
    input  logic                        i_out_free,
    output afr_pkg::t_emit              o_emit,
    output logic                        o_mem_we,
    output logic [$clog2(CAPACITY)-1:0] o_mem_waddr,
    output afr_pkg::t_byte              o_mem_wdata,
    output logic                        o_mem_re,
    output logic [$clog2(CAPACITY)-1:0] o_mem_raddr
);
    import afr_pkg::*;

    localparam int   ADDR_W   = $clog2(CAPACITY);
    localparam t_len FULL_LIM = LEN_W'(CAPACITY - 2);

    logic [ST_W-1:0] r_state, n_state;
    t_len            r_fill, n_fill;
    t_len            r_idx, n_idx;
    t_byte           r_station_id;
    logic            w_accept;
    logic            w_is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_id <= '0;
        end else if (i_cfg_we) begin
            r_station_id <= i_cfg_wdata;
        end
    end

    assign o_in_ready = (r_state != S_RD) && (r_state != S_OUT);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_is_last  = (r_idx == r_fill - 1'b1);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_idx       = r_idx;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_fill[ADDR_W-1:0];
        o_mem_wdata = i_in_byte;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_idx[ADDR_W-1:0];
        o_emit      = '{load: 1'b0, is_last: w_is_last, frame_length: r_fill};
        if (w_accept && i_in_byte == START_BYTE) begin
            n_state = S_ADDR;
            n_fill  = '0;
        end else begin
            case (r_state)
                S_ADDR: begin
                    if (w_accept) begin
                        if (i_in_byte == r_station_id) begin
                            n_state = S_FILL;
                        end else begin
                            n_state = S_IDLE;
                            n_fill  = '0;
                        end
                    end
                end
                S_FILL: begin
                    if (w_accept) begin
                        if (i_in_byte == STOP_BYTE) begin
                            if (r_fill > MIN_KEEP) begin
                                n_state = S_RD;
                                n_idx   = '0;
                            end else begin
                                n_state = S_IDLE;
                                n_fill  = '0;
                            end
                        end else if (r_fill > FULL_LIM) begin
                            n_state = S_IDLE;
                            n_fill  = '0;
                        end else begin
                            o_mem_we = 1'b1;
                            n_fill   = r_fill + 1'b1;
                        end
                    end
                end
                S_RD: begin
                    o_mem_re = 1'b1;
                    n_state  = S_OUT;
                end
                S_OUT: begin
                    if (i_out_free) begin
                        o_emit.load = 1'b1;
                        if (w_is_last) begin
                            n_state = S_READY;
                        end else begin
                            n_idx   = r_idx + 1'b1;
                            n_state = S_RD;
                        end
                    end
                end
                default: begin
                    n_state = r_state;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_idx   <= n_idx;
        end
    end

endmodule

@@ rtl/core/afr_out_stage.sv @@
// Output register of the receiver that holds one payload word until it is taken.
// Depends on afr_pkg and afr_out_if.
module afr_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  afr_pkg::t_emit    i_emit,
    input  afr_pkg::t_byte    i_data,
    output logic              o_free,
    afr_out_if.source         o_out
);
    import afr_pkg::*;

    logic  r_valid;
    t_byte r_byte;
    logic  r_last;
    t_len  r_len;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_emit.load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.load) begin
            r_byte <= i_data;
            r_last <= i_emit.is_last;
            r_len  <= i_emit.frame_length;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.payload_byte = r_byte;
    assign o_out.is_last      = r_last;
    assign o_out.frame_length = r_len;

endmodule

@@ rtl/core/addressed_frame_receiver_top.sv @@
// Channel    Dir  Word
// i_rx       in   rx_byte: one received byte
// o_frame    out  payload_byte, is_last, frame_length: one stored byte of a valid frame
// i_cfg_*    in   station id write, taken at any edge with i_cfg_we high and i_rst_n high
//
// i_rx.ready is low only while a frame is sent.
// A frame is sent byte by byte: each byte is read from the frame store, then loaded into the output register.
// A stall on o_frame holds the sequencer; the input waits until the last byte is loaded.
// Reset is synchronous and active low; the frame store is not cleared.
// Top level of the addressed frame receiver.
// Depends on afr_pkg, afr_in_if, afr_out_if, afr_ram, afr_ctrl and afr_out_stage.
module addressed_frame_receiver_top #(
    parameter int CAPACITY = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  afr_pkg::t_byte i_cfg_wdata,
    afr_in_if.sink         i_rx,
    afr_out_if.source      o_frame
);
    import afr_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);

    t_emit             w_emit;
    logic              w_out_free;
    logic              w_mem_we;
    logic [ADDR_W-1:0] w_mem_waddr;
    t_byte             w_mem_wdata;
    logic              w_mem_re;
    logic [ADDR_W-1:0] w_mem_raddr;
    t_byte             w_mem_rdata;

    afr_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_rx.valid),
        .i_in_byte   (i_rx.rx_byte),
        .o_in_ready  (i_rx.ready),
        .i_out_free  (w_out_free),
        .o_emit      (w_emit),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_re    (w_mem_re),
        .o_mem_raddr (w_mem_raddr)
    );

    afr_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    afr_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (w_emit),
        .i_data  (w_mem_rdata),
        .o_free  (w_out_free),
        .o_out   (o_frame)
    );

`ifndef SYNTH
    a_load_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit.load |-> !i_rx.ready)
        else $error("Input ready while a frame word is loaded.");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit.load |-> w_out_free)
        else $error("Frame word loaded over a word not yet taken.");

    a_last_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit.load && w_emit.is_last) |=> i_rx.ready)
        else $error("Input not ready after the last word of a frame.");

    a_read_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit.load && !w_emit.is_last) |=> w_mem_re)
        else $error("No frame store read after a frame word that is not the last.");
`endif

endmodule
